/* hw/rtl/text_mode_terminal_writer_unit_assert.svh */
// Assertion macros for the text-mode terminal writer.
// Included by the top level; depends on nothing else.
`ifndef TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define TMTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmtw assertion failed");

// Next-cycle implication, checked while out of reset.
`define TMTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmtw assertion failed");

`endif

/* hw/rtl/tmtw_pkg.sv */
// Package for the text-mode terminal writer: request codes, cell constants,
// and the command and status structs between controller and datapath.
// No dependencies.
package tmtw_pkg;

  // Default screen geometry.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Cell constants.
  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [3:0]  COLOR_WHITE  = 4'hF;
  localparam logic [3:0]  COLOR_BLACK  = 4'h0;
  localparam logic [15:0] BLANK_CELL   = {COLOR_BLACK, COLOR_WHITE, SPACE_CODE};

  // Request codes carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } tmtw_req_t;

  // Source of the cell written to the screen memory.
  typedef enum logic [1:0] {
    WD_CHAR  = 2'd0,
    WD_MOVE  = 2'd1,
    WD_BLANK = 2'd2,
    WD_FILL  = 2'd3
  } tmtw_wsel_t;

  // Source of the screen memory read address.
  typedef enum logic {
    RD_INDEX  = 1'b0,
    RD_SCROLL = 1'b1
  } tmtw_rsel_t;

  // Controller to datapath.
  typedef struct packed {
    logic       latch_req;
    logic       cur_put;
    logic       wr_en;
    logic       wa_cursor;
    tmtw_wsel_t wsel;
    logic       rd_en;
    tmtw_rsel_t rsel;
    logic       cnt_clr;
    logic       cnt_bottom;
    logic       cnt_inc;
    logic       data_clr;
    logic       data_load;
    logic       out_load;
  } tmtw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] req;
    logic       is_newline;
    logic       wrap;
    logic       last_row;
    logic       idx_ok;
    logic       cnt_scroll_end;
    logic       cnt_end;
    logic       out_free;
  } tmtw_status_t;

endpackage

/* hw/rtl/tmtw_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tmtw_ctrl.sv */
// Controller state machine of the text-mode terminal writer.
// Depends on tmtw_pkg for the command and status structs.
module tmtw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  tmtw_pkg::tmtw_status_t status,
  output tmtw_pkg::tmtw_cmd_t    cmd
);
  import tmtw_pkg::*;

  typedef enum logic [8:0] {
    S_INIT      = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_EXEC      = 9'b000000100,
    S_READ_WAIT = 9'b000001000,
    S_SCROLL_RD = 9'b000010000,
    S_SCROLL_WR = 9'b000100000,
    S_BLANK     = 9'b001000000,
    S_FILL      = 9'b010000000,
    S_RESULT    = 9'b100000000
  } tmtw_state_t;

  tmtw_state_t state_r;
  tmtw_state_t state_nxt;

  // State register; reset starts the blanking pass over the screen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WD_BLANK;
        if (status.cnt_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.data_clr = 1'b1;
        case (status.req)
          REQ_PUT: begin
            cmd.cur_put   = 1'b1;
            cmd.wr_en     = !status.is_newline;
            cmd.wa_cursor = 1'b1;
            cmd.wsel      = WD_CHAR;
            if (status.wrap && status.last_row) begin
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_SCROLL_RD;
            end else begin
              state_nxt = S_RESULT;
            end
          end
          REQ_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_FILL;
          end
          REQ_READ: begin
            if (status.idx_ok) begin
              cmd.rd_en = 1'b1;
              cmd.rsel  = RD_INDEX;
              state_nxt = S_READ_WAIT;
            end else begin
              state_nxt = S_RESULT;
            end
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end
      S_READ_WAIT: begin
        cmd.data_load = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_SCROLL_RD: begin
        cmd.rd_en = 1'b1;
        cmd.rsel  = RD_SCROLL;
        state_nxt = S_SCROLL_WR;
      end
      S_SCROLL_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WD_MOVE;
        if (status.cnt_scroll_end) begin
          cmd.cnt_bottom = 1'b1;
          state_nxt      = S_BLANK;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_SCROLL_RD;
        end
      end
      S_BLANK: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WD_BLANK;
        if (status.cnt_end) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FILL: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WD_FILL;
        if (status.cnt_end) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/tmtw_dpath.sv */
// Datapath of the text-mode terminal writer: request latch, cursor, sweep
// counter, screen memory and output register. Depends on tmtw_pkg and tmtw_ram.
module tmtw_dpath #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_req_type,
  input  logic [7:0]            in_char_code,
  input  logic [7:0]            in_attribute,
  input  logic [10:0]           in_cell_index,
  input  tmtw_pkg::tmtw_cmd_t    cmd,
  output tmtw_pkg::tmtw_status_t status,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [15:0]           out_read_data,
  output logic [6:0]            out_cursor_col,
  output logic [4:0]            out_cursor_row
);
  import tmtw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int XW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int YW     = $clog2(ROWS);

  logic [1:0]        req_type_r;
  logic [7:0]        req_char_r;
  logic [7:0]        req_attr_r;
  logic [10:0]       req_idx_r;
  logic [XW-1:0]     cursor_x_r;
  logic [XW-1:0]     cursor_x_nxt;
  logic [YW-1:0]     cursor_y_r;
  logic [YW-1:0]     cursor_y_nxt;
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] cnt_nxt;
  logic [15:0]       data_r;
  logic              out_tvalid_r;
  logic [15:0]       out_data_r;
  logic [6:0]        out_col_r;
  logic [4:0]        out_row_r;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;
  logic [15:0]       rdata;
  logic              wrap;

  // Request latch, loaded when the item is accepted.
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_req_type;
      req_char_r <= in_char_code;
      req_attr_r <= in_attribute;
      req_idx_r  <= in_cell_index;
    end
  end

  // Cursor advance: wrap at the last column or on a newline.
  assign wrap = (req_char_r == NEWLINE_CODE) || (cursor_x_r == XW'(COLUMNS - 1));

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (cmd.cur_put) begin
      if (wrap) begin
        cursor_x_nxt = '0;
        if (cursor_y_r != YW'(ROWS - 1)) begin
          cursor_y_nxt = cursor_y_r + 1'b1;
        end
      end else begin
        cursor_x_nxt = cursor_x_r + 1'b1;
      end
    end
  end

  // Sweep counter for scroll, clear and the reset blanking pass.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_bottom) begin
      cnt_nxt = ADDR_W'(CELLS - COLUMNS);
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      cnt_r      <= '0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Memory addresses and write data.
  assign cur_addr = ADDR_W'(cursor_y_r) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_x_r);
  assign waddr    = cmd.wa_cursor ? cur_addr : cnt_r;
  assign raddr    = (cmd.rsel == RD_SCROLL) ? (cnt_r + ADDR_W'(COLUMNS))
                                            : ADDR_W'(req_idx_r);

  always_comb begin
    case (cmd.wsel)
      WD_CHAR:  wdata = {req_attr_r, req_char_r};
      WD_MOVE:  wdata = rdata;
      WD_BLANK: wdata = BLANK_CELL;
      WD_FILL:  wdata = {req_attr_r[7:4], COLOR_WHITE, SPACE_CODE};
      default:  wdata = BLANK_CELL;
    endcase
  end

  tmtw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS),
    .AW    (ADDR_W)
  ) u_screen (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read result; zero for every request but an in-range read.
  always_ff @(posedge clk) begin
    if (cmd.data_clr) begin
      data_r <= '0;
    end else if (cmd.data_load) begin
      data_r <= rdata;
    end
  end

  // Output register: holds one finished item until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= data_r;
      out_col_r  <= 7'(cursor_x_r);
      out_row_r  <= 5'(cursor_y_r);
    end
  end

  assign out_tvalid     = out_tvalid_r;
  assign out_read_data  = out_data_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

  // Status back to the controller.
  assign status.req            = req_type_r;
  assign status.is_newline     = (req_char_r == NEWLINE_CODE);
  assign status.wrap           = wrap;
  assign status.last_row       = (cursor_y_r == YW'(ROWS - 1));
  assign status.idx_ok         = (32'(req_idx_r) < CELLS);
  assign status.cnt_scroll_end = (cnt_r == ADDR_W'(CELLS - COLUMNS - 1));
  assign status.cnt_end        = (cnt_r == ADDR_W'(CELLS - 1));
  assign status.out_free       = !out_tvalid_r || out_tready;

endmodule

/* hw/rtl/text_mode_terminal_writer_unit.sv */
// Top level of the text-mode terminal writer.
// Depends on tmtw_pkg, tmtw_ctrl, tmtw_dpath and the assertion macro header.
//
// The block keeps a COLUMNS x ROWS screen of 16-bit cells (attribute high,
// character low) and a cursor, and answers each request item with one result
// item holding the read cell and the cursor after the request. After reset
// the block blanks every cell of the screen before it takes its first item.
// An item is taken only in the idle state, so the sweep over the screen
// memory sets the rate. A put, an unused request code or a read past the
// screen goes through the execute and result states, a read on the screen
// adds a read wait state between them, a clear sweeps every cell, and a put
// that scrolls moves each cell below the top row up one row and blanks the
// bottom row; each moved cell needs one memory read and one write. A finished
// result waits in the output register, and the next item is accepted while it waits.
`include "text_mode_terminal_writer_unit_assert.svh"

module text_mode_terminal_writer_unit #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // read_data[15:0], cursor_col[22:16], cursor_row[27:23]
);
  import tmtw_pkg::*;

  tmtw_cmd_t    cmd;
  tmtw_status_t status;
  logic [15:0]  out_read_data;
  logic [6:0]   out_cursor_col;
  logic [4:0]   out_cursor_row;

  // Controller.
  tmtw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath.
  tmtw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_tuser),
    .in_char_code   (in_tdata[7:0]),
    .in_attribute   (in_tdata[15:8]),
    .in_cell_index  (in_tdata[26:16]),
    .cmd            (cmd),
    .status         (status),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_read_data  (out_read_data),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row)
  );

  // Result packing.
  assign out_tdata = {4'b0000, out_cursor_row, out_cursor_col, out_read_data};

  // An accepted item takes the block out of idle at once.
  `TMTW_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A result is only loaded when the output register can take it.
  `TMTW_ASSERT_NOW(a_out_free, clk, rst_n, cmd.out_load, status.out_free)
  // The reported column always lies on the screen.
  `TMTW_ASSERT_NOW(a_col_range, clk, rst_n, out_tvalid, 32'(out_tdata[22:16]) < COLUMNS)

endmodule

/* tb/tb_text_mode_terminal_writer_unit.sv */
// Self-checking testbench for the text-mode terminal writer.
// It depends on tmtw_pkg and the text_mode_terminal_writer_unit RTL.
// A screen predictor forecasts each result item, and a checker compares it field by field.
module tb_text_mode_terminal_writer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam int CELLS = COLUMNS * ROWS;
  localparam real CLK_HALF_PERIOD = 2.0;
  localparam int RESET_CYCLES = 7;
  // A scroll holds the block longer than the blanking pass after reset does.
  // The limit allows several times the length of a scroll.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_PRINTED = 50;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // One predicted result item.
  typedef struct {
    logic [15:0] read_data;
    logic [6:0]  col;
    logic [4:0]  row;
  } screen_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // char_code[7:0], attribute[15:8], cell_index[26:16]
  logic [1:0]  in_tuser = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // read_data[15:0], cursor_col[22:16], cursor_row[27:23]

  // Predictor state: the screen and the cursor as the block should hold them.
  logic [15:0]    screen_model [CELLS];
  int unsigned    model_col;
  int unsigned    model_row;
  screen_report_t pending_reports [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_puts = 0, n_newlines = 0, n_scrolls = 0, n_clears = 0;
  int unsigned n_reads = 0, n_reads_oob = 0, n_unused = 0;

  text_mode_terminal_writer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF_PERIOD) clk = ~clk;

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    end
  endtask

  // Moves the cursor down a row. On the last row the screen scrolls up instead.
  task automatic model_line_feed();
    int i;
    if (model_row >= ROWS - 1) begin
      model_row = ROWS - 1;
      for (i = 0; i + COLUMNS < CELLS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      for (i = CELLS - COLUMNS; i < CELLS; i++) begin
        screen_model[i] = BLANK_CELL;
      end
      n_scrolls++;
    end else begin
      model_row++;
    end
  endtask

  // Applies one accepted request to the model and queues the result it should give.
  task automatic predict_screen_request(input logic [1:0] req, input logic [7:0] ch,
                                        input logic [7:0] attr, input logic [10:0] idx);
    screen_report_t rep;
    int i;
    rep.read_data = '0;
    case (req)
      REQ_PUT: begin
        n_puts++;
        if (ch == NEWLINE_CODE) begin
          n_newlines++;
          model_col = 0;
          model_line_feed();
        end else begin
          screen_model[model_row * COLUMNS + model_col] = {attr, ch};
          model_col++;
          if (model_col >= COLUMNS) begin
            model_col = 0;
            model_line_feed();
          end
        end
      end
      REQ_CLEAR: begin
        n_clears++;
        for (i = 0; i < CELLS; i++) begin
          screen_model[i] = {attr[7:4], COLOR_WHITE, SPACE_CODE};
        end
      end
      REQ_READ: begin
        n_reads++;
        if (idx < CELLS) begin
          rep.read_data = screen_model[idx];
        end else begin
          n_reads_oob++;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    rep.col = model_col[6:0];
    rep.row = model_row[4:0];
    pending_reports.push_back(rep);
  endtask

  // Sends one item after a random gap. The caller is at a rising edge, and the task
  // returns at the edge that accepted the item.
  task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                              input logic [7:0] attr, input logic [10:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, idx, attr, ch};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predict_screen_request(req, ch, attr, idx);
  endtask

  task automatic put_char(input logic [7:0] ch, input logic [7:0] attr);
    send_request(REQ_PUT, ch, attr, 11'($urandom_range(2047)));
  endtask

  task automatic read_cell(input int unsigned idx);
    send_request(REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), 11'(idx));
  endtask

  task automatic clear_screen(input logic [7:0] attr);
    send_request(REQ_CLEAR, 8'($urandom_range(255)), attr, 11'($urandom_range(2047)));
  endtask

  // The screen after reset: the first and last cells, the first index past the end and the largest index.
  task automatic test_reset_screen();
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(2047);
  endtask

  // Puts with extreme and ordinary bytes, then a newline, with the cells read back.
  task automatic test_put_extremes();
    put_char(8'hFF, 8'hFF);
    put_char(8'h00, 8'h00);
    put_char(SPACE_CODE, 8'h5A);
    put_char(NEWLINE_CODE, 8'hFF);
    read_cell(0);
    read_cell(1);
    read_cell(2);
    read_cell(COLUMNS);
  endtask

  // The spare request code must leave the screen and the cursor unchanged.
  task automatic test_unused_code();
    send_request(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
    read_cell(0);
  endtask

  // Clears with several backgrounds. The low nibble of the attribute is ignored,
  // and the cursor stays where it is.
  task automatic test_clear();
    clear_screen(8'hA5);
    read_cell(0);
    read_cell(CELLS - 1);
    clear_screen(8'h0F);
    clear_screen(8'hF0);
    read_cell(12 * COLUMNS + 40);
  endtask

  // Fills the rest of a row and goes past the end of it, then reads the row back.
  task automatic test_line_wrap();
    int unsigned row_start;
    repeat (COLUMNS - model_col + 5) begin
      put_char(8'($urandom_range(32, 126)), 8'($urandom_range(255)));
    end
    row_start = (model_row - 1) * COLUMNS;
    read_cell(row_start);
    read_cell(row_start + COLUMNS - 1);
    repeat (4) read_cell(row_start + $urandom_range(COLUMNS - 1));
  endtask

  // Moves down to the last row, scrolls by newline and then by wrapping,
  // and checks the rows that moved up and the new blank bottom row.
  task automatic test_scroll();
    while (model_row < ROWS - 1) begin
      put_char(NEWLINE_CODE, 8'($urandom_range(255)));
    end
    repeat (3) put_char(8'($urandom_range(32, 126)), 8'($urandom_range(255)));
    put_char(NEWLINE_CODE, 8'($urandom_range(255)));
    read_cell((ROWS - 2) * COLUMNS);
    read_cell((ROWS - 2) * COLUMNS + 2);
    read_cell((ROWS - 1) * COLUMNS);
    repeat (COLUMNS) put_char(8'($urandom_range(255)) | 8'h80, 8'($urandom_range(255)));
    read_cell((ROWS - 2) * COLUMNS + COLUMNS - 1);
    read_cell(CELLS - 1);
  endtask

  // A random mix of requests. Most reads land near the cursor, where recent writes are.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    int unsigned r;
    logic [7:0]  ch;
    logic [7:0]  attr;
    logic [10:0] idx;
    repeat (count) begin
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      attr = 8'($urandom_range(255));
      idx  = 11'($urandom_range(2047));
      if (pick < 50) begin
        send_request(REQ_PUT, ch, attr, idx);
      end else if (pick < 56) begin
        send_request(REQ_PUT, NEWLINE_CODE, attr, idx);
      end else if (pick < 94) begin
        if (pick < 84) begin
          r = (model_row > 0 && $urandom_range(1) == 1) ? model_row - 1 : model_row;
          idx = 11'(r * COLUMNS + $urandom_range(COLUMNS - 1));
        end else if (pick >= 90) begin
          idx = 11'($urandom_range(2047, CELLS));
        end
        send_request(REQ_READ, ch, attr, idx);
      end else if (pick < 97) begin
        send_request(REQ_CLEAR, ch, attr, idx);
      end else begin
        send_request(REQ_UNUSED, ch, attr, idx);
      end
    end
  endtask

  // Checks each accepted result item against the oldest prediction and sets the stalls.
  always @(posedge clk) begin : check_results
    screen_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, 0);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[15:0] !== want.read_data) begin
          report_mismatch("read_data", out_tdata[15:0], want.read_data);
        end
        if (out_tdata[22:16] !== want.col) begin
          report_mismatch("cursor_col", out_tdata[22:16], want.col);
        end
        if (out_tdata[27:23] !== want.row) begin
          report_mismatch("cursor_row", out_tdata[27:23], want.row);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when no item has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = BLANK_CELL;
    end
    model_col = 0;
    model_row = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The sender idles lightly and the receiver stalls heavily.
    send_idle_pct = 25;
    recv_idle_pct = 60;
    test_reset_screen();
    test_put_extremes();
    test_unused_code();
    test_clear();
    test_line_wrap();
    test_scroll();
    test_random_traffic(300);

    // The other way round, and then with no idling on either side.
    send_idle_pct = 60;
    recv_idle_pct = 25;
    test_random_traffic(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(320);
    in_tvalid <= 1'b0;

    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d puts (%0d newlines), %0d scrolls, %0d clears, %0d unused codes",
             n_puts, n_newlines, n_scrolls, n_clears, n_unused);
    $display("and %0d reads (%0d past the screen); %0d mismatches",
             n_reads, n_reads_oob, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
